FILE: hdl/lfsa_pkg.sv
`timescale 1ns / 1ps
// Package for the lowest-free slot allocator with wait queue.
// Holds shared codes, the chain transaction type and default sizes; no dependencies.
package lfsa_pkg;

    // Default sizes
    localparam int SLOTS_DEF      = 128;
    localparam int REQUESTERS_DEF = 2048;

    // Fixed field widths
    localparam int ID_W    = 11;
    localparam int VAL_W   = 16;
    localparam int COST_W  = 48;
    localparam int CFG_W   = 8;
    localparam int GIVEN_W = 7;

    // slots_in_use after reset
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 8'd128;

    // Input commands
    typedef enum logic [1:0] {
        CMD_LOAD_RATE   = 2'd0,
        CMD_LOAD_WEIGHT = 2'd1,
        CMD_ARRIVE      = 2'd2,
        CMD_DEPART      = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        RES_LOADED    = 3'd0,
        RES_PLACED    = 3'd1,
        RES_QUEUED    = 3'd2,
        RES_FREED     = 3'd3,
        RES_SERVED    = 3'd4,
        RES_NOT_FOUND = 3'd5
    } status_t;

    // Operation carried down the cell chain
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    // Transaction moving one cell per cycle
    typedef struct packed {
        logic             valid;
        op_t              op;
        logic [ID_W-1:0]  id;     // requester id, or slot number for loads
        logic [VAL_W-1:0] value;  // rate to load
        logic             hit;    // a cell already acted on this transaction
        logic [VAL_W-1:0] rate;   // rate of the hit slot
    } tok_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PASS,
        ST_FIFO_RD,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    // What the running chain pass is for
    typedef enum logic [1:0] {
        PH_LOAD,
        PH_ARRIVE,
        PH_DEPART,
        PH_SERVE
    } phase_t;

endpackage

FILE: hdl/lfsa_cell.sv
`timescale 1ns / 1ps
// One slot cell: holds the slot's holder id and rate, acts on a passing transaction.
// Depends on lfsa_pkg.
module lfsa_cell #(
    parameter int IDX    = 0,
    parameter int SLOT_W = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lfsa_pkg::CFG_W-1:0] slots_in_use,
    input  lfsa_pkg::tok_t             tok_in,
    input  logic [SLOT_W-1:0]          slot_in,
    output lfsa_pkg::tok_t             tok_out,
    output logic [SLOT_W-1:0]          slot_out
);
    import lfsa_pkg::*;

    logic [ID_W-1:0]   holder_reg;
    logic [ID_W-1:0]   holder_next;
    logic [VAL_W-1:0]  rate_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              active;
    logic              do_claim;
    logic              do_release;
    logic              do_load;

    // Slot is searchable only inside the configured range
    assign active = ID_W'(IDX) < {{(ID_W-CFG_W){1'b0}}, slots_in_use};

    // Local decisions
    assign do_claim   = tok_in.valid && (tok_in.op == OP_CLAIM) && !tok_in.hit
                        && active && (holder_reg == '0);
    assign do_release = tok_in.valid && (tok_in.op == OP_RELEASE) && !tok_in.hit
                        && active && (holder_reg == tok_in.id);
    assign do_load    = tok_in.valid && (tok_in.op == OP_LOAD)
                        && (tok_in.id == ID_W'(IDX));

    // Transaction handed to the next cell
    always_comb
    begin
        tok_next    = tok_in;
        slot_next   = slot_in;
        holder_next = holder_reg;
        if (do_claim || do_release)
        begin
            tok_next.hit  = 1'b1;
            tok_next.rate = rate_reg;
            slot_next     = SLOT_W'(IDX);
        end
        if (do_claim)
        begin
            holder_next = tok_in.id;
        end
        else if (do_release)
        begin
            holder_next = '0;
        end
    end

    // Holder and forwarding registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holder_reg <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            holder_reg <= holder_next;
            tok_reg    <= tok_next;
        end
    end

    // Rate and slot number carry no reset
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            rate_reg <= tok_in.value;
        end
        slot_reg <= slot_next;
    end

    assign tok_out  = tok_reg;
    assign slot_out = slot_reg;

endmodule

FILE: hdl/lfsa_chain.sv
`timescale 1ns / 1ps
// Row of slot cells, lowest slot first; a transaction crosses one cell per cycle.
// Depends on lfsa_pkg and lfsa_cell.
module lfsa_chain #(
    parameter int SLOTS  = lfsa_pkg::SLOTS_DEF,
    parameter int SLOT_W = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lfsa_pkg::CFG_W-1:0] slots_in_use,
    input  lfsa_pkg::tok_t             tok_in,
    output lfsa_pkg::tok_t             tok_out,
    output logic [SLOT_W-1:0]          slot_out
);
    import lfsa_pkg::*;

    tok_t              tok_link  [SLOTS+1];
    logic [SLOT_W-1:0] slot_link [SLOTS+1];

    assign tok_link[0]  = tok_in;
    assign slot_link[0] = '0;

    // Cell row
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        lfsa_cell #(
            .IDX    (i),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .slots_in_use (slots_in_use),
            .tok_in       (tok_link[i]),
            .slot_in      (slot_link[i]),
            .tok_out      (tok_link[i+1]),
            .slot_out     (slot_link[i+1])
        );
    end

    assign tok_out  = tok_link[SLOTS];
    assign slot_out = slot_link[SLOTS];

endmodule

FILE: hdl/lowest_free_slot_allocator_fifo_wait_unit.sv
`timescale 1ns / 1ps
// Top level of the slot allocator: controller, weight table, wait queue, cost total.
// Depends on lfsa_pkg and lfsa_chain.
//
// Usage
//   Command channel: a transaction (cmd, index, value) is taken at a rising edge with
//   start high and busy low. busy stays high until the result has been shown.
//   Result channel: done is high for exactly one cycle with status, slot_given,
//   served_id and total_cost valid; the receiver must take it in that cycle.
//   Configuration: cfg_we with cfg_wdata writes slots_in_use; write only while idle.
// Command flow
//   Weight load or rejected id: no pass down the row; decode goes straight to done.
//   Rate load and arrival: one pass; a placed arrival then multiplies and adds its cost.
//   Departure: one pass, then a queue read, a second pass and the cost step when a waiter is served.
//   Every search runs one pass down the slot cell row, one cell per cycle, so the
//   row length sets the rate; one command is handled at a time.
// Reset
//   All slots free, queue empty, total zero, slots_in_use = 128. Rate and weight
//   tables hold no defined value until loaded. No clearing pass is needed.
module lowest_free_slot_allocator_fifo_wait_unit #(
    parameter int SLOTS      = lfsa_pkg::SLOTS_DEF,
    parameter int REQUESTERS = lfsa_pkg::REQUESTERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lfsa_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic [lfsa_pkg::ID_W-1:0]    index,
    input  logic [lfsa_pkg::VAL_W-1:0]   value,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [lfsa_pkg::GIVEN_W-1:0] slot_given,
    output logic [lfsa_pkg::ID_W-1:0]    served_id,
    output logic [lfsa_pkg::COST_W-1:0]  total_cost
);
    import lfsa_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REQ_W  = $clog2(REQUESTERS);
    localparam int CNT_W  = REQ_W + 1;

    // Control and datapath registers
    state_t              state_reg;
    state_t              state_next;
    phase_t              phase_reg;
    cmd_t                cmd_reg;
    logic [ID_W-1:0]     id_reg;
    logic [VAL_W-1:0]    value_reg;
    logic [CFG_W-1:0]    slots_in_use_reg;
    tok_t                launch_reg;
    logic [REQ_W-1:0]    head_reg;
    logic [REQ_W-1:0]    tail_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [COST_W-1:0]   cost_reg;
    logic [VAL_W-1:0]    rate_reg;
    logic [2*VAL_W-1:0]  prod_reg;
    status_t             status_reg;
    logic [GIVEN_W-1:0]  given_reg;
    logic [ID_W-1:0]     served_reg;

    // Memories and their read registers
    logic [VAL_W-1:0]    weight_mem [REQUESTERS];
    logic [VAL_W-1:0]    weight_q;
    logic [ID_W-1:0]     fifo_mem [REQUESTERS];
    logic [ID_W-1:0]     fifo_q;

    // Chain ports
    tok_t                chain_out;
    logic [SLOT_W-1:0]   chain_slot;

    // Decode helpers
    logic                id_ok;
    logic                fifo_full;
    logic                fifo_empty;
    logic                weight_we;
    logic                weight_re;
    logic [REQ_W-1:0]    weight_raddr;
    logic                fifo_we;
    logic [REQ_W-1:0]    head_inc;
    logic [REQ_W-1:0]    tail_inc;
    logic                launch_cmd;
    logic                launch_serve;

    assign id_ok      = (id_reg != '0) && (32'(id_reg) < REQUESTERS);
    assign fifo_full  = count_reg == CNT_W'(REQUESTERS);
    assign fifo_empty = count_reg == '0;
    assign head_inc   = (head_reg == REQ_W'(REQUESTERS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == REQ_W'(REQUESTERS - 1)) ? '0 : tail_reg + 1'b1;

    // Pass launches: the command itself, or serving the queue head
    assign launch_cmd   = (state_reg == ST_DECODE) && (cmd_reg == CMD_LOAD_RATE
                          || ((cmd_reg == CMD_ARRIVE || cmd_reg == CMD_DEPART) && id_ok));
    assign launch_serve = state_reg == ST_FIFO_RD;

    // Slot cell row
    lfsa_chain #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .slots_in_use (slots_in_use_reg),
        .tok_in       (launch_reg),
        .tok_out      (chain_out),
        .slot_out     (chain_slot)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (cmd_reg == CMD_LOAD_RATE)
                begin
                    state_next = ST_PASS;
                end
                else if (cmd_reg == CMD_LOAD_WEIGHT || !id_ok)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (chain_out.valid)
                begin
                    if (chain_out.hit && (phase_reg == PH_ARRIVE || phase_reg == PH_SERVE))
                    begin
                        state_next = ST_MUL;
                    end
                    else if (chain_out.hit && phase_reg == PH_DEPART && !fifo_empty)
                    begin
                        state_next = ST_FIFO_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FIFO_RD: state_next = ST_PASS;
            ST_MUL:     state_next = ST_ADD;
            ST_ADD:     state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        busy = state_reg != ST_IDLE;
        done = state_reg == ST_DONE;
    end

    // Memory enables
    always_comb
    begin
        weight_we    = (state_reg == ST_DECODE) && (cmd_reg == CMD_LOAD_WEIGHT)
                       && (32'(id_reg) < REQUESTERS);
        weight_re    = ((state_reg == ST_DECODE) && (cmd_reg == CMD_ARRIVE))
                       || (state_reg == ST_FIFO_RD);
        weight_raddr = (state_reg == ST_FIFO_RD) ? REQ_W'(fifo_q) : REQ_W'(id_reg);
        fifo_we      = (state_reg == ST_PASS) && chain_out.valid && (phase_reg == PH_ARRIVE)
                       && !chain_out.hit && !fifo_full;
    end

    // Weight table
    always_ff @(posedge clk)
    begin
        if (weight_we)
        begin
            weight_mem[REQ_W'(id_reg)] <= value_reg;
        end
        if (weight_re)
        begin
            weight_q <= weight_mem[weight_raddr];
        end
    end

    // Wait queue storage, head entry read every cycle
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[tail_reg] <= id_reg;
        end
        fifo_q <= fifo_mem[head_reg];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slots_in_use_reg <= SLOTS_IN_USE_RST;
            launch_reg       <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            cost_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            launch_reg.valid <= launch_cmd || launch_serve;
            if (cfg_we)
            begin
                slots_in_use_reg <= cfg_wdata;
            end
            // Launch a pass down the row
            if (launch_cmd)
            begin
                launch_reg.id    <= id_reg;
                launch_reg.value <= value_reg;
                launch_reg.hit   <= 1'b0;
                launch_reg.rate  <= '0;
                case (cmd_reg)
                    CMD_LOAD_RATE: launch_reg.op <= OP_LOAD;
                    CMD_ARRIVE:    launch_reg.op <= OP_CLAIM;
                    default:       launch_reg.op <= OP_RELEASE;
                endcase
            end
            else if (launch_serve)
            begin
                launch_reg.op    <= OP_CLAIM;
                launch_reg.id    <= fifo_q;
                launch_reg.value <= '0;
                launch_reg.hit   <= 1'b0;
                launch_reg.rate  <= '0;
            end
            // Queue pointers
            if (fifo_we)
            begin
                tail_reg  <= tail_inc;
                count_reg <= count_reg + 1'b1;
            end
            else if (state_reg == ST_FIFO_RD)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            // Running total
            if (state_reg == ST_ADD)
            begin
                cost_reg <= cost_reg + COST_W'(prod_reg);
            end
        end
    end

    // Command latch, pass results and cost product
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg   <= cmd_t'(cmd);
            id_reg    <= index;
            value_reg <= value;
        end
        case (state_reg)
            ST_DECODE:
            begin
                given_reg  <= '0;
                served_reg <= '0;
                case (cmd_reg)
                    CMD_LOAD_RATE:
                    begin
                        phase_reg  <= PH_LOAD;
                        status_reg <= RES_LOADED;
                    end
                    CMD_LOAD_WEIGHT: status_reg <= RES_LOADED;
                    CMD_ARRIVE:
                    begin
                        phase_reg  <= PH_ARRIVE;
                        status_reg <= RES_NOT_FOUND;
                    end
                    default:
                    begin
                        phase_reg  <= PH_DEPART;
                        status_reg <= RES_NOT_FOUND;
                    end
                endcase
            end
            ST_PASS:
            begin
                if (chain_out.valid)
                begin
                    rate_reg <= chain_out.rate;
                    case (phase_reg)
                        PH_ARRIVE:
                        begin
                            if (chain_out.hit)
                            begin
                                status_reg <= RES_PLACED;
                                given_reg  <= GIVEN_W'(chain_slot);
                                served_reg <= id_reg;
                            end
                            else if (!fifo_full)
                            begin
                                status_reg <= RES_QUEUED;
                            end
                        end
                        PH_DEPART:
                        begin
                            if (chain_out.hit)
                            begin
                                status_reg <= RES_FREED;
                            end
                        end
                        PH_SERVE:
                        begin
                            if (chain_out.hit)
                            begin
                                status_reg <= RES_SERVED;
                                given_reg  <= GIVEN_W'(chain_slot);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FIFO_RD:
            begin
                phase_reg  <= PH_SERVE;
                served_reg <= fifo_q;
            end
            ST_MUL: prod_reg <= weight_q * rate_reg;
            default: ;
        endcase
    end

    // Result ports
    assign status     = status_reg;
    assign slot_given = given_reg;
    assign served_id  = served_reg;
    assign total_cost = cost_reg;

    // Checks on the controller
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(REQUESTERS))
        else $error("wait queue count exceeds depth");

    a_chain_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == ST_PASS))
        else $error("chain transaction returned outside a pass");

    a_given_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (slot_given == '0 || status_reg == RES_PLACED
                  || status_reg == RES_SERVED))
        else $error("slot reported without placement");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the lowest-free slot allocator with wait queue.
// Depends on lfsa_pkg and lowest_free_slot_allocator_fifo_wait_unit; the allocator is
// predicted in place and every result transaction is checked field by field.
module tb_top;
    import lfsa_pkg::*;

    localparam int SLOT_COUNT    = SLOTS_DEF;
    localparam int REQ_COUNT     = REQUESTERS_DEF;
    localparam int VAL_MAX       = 16'hFFFF;
    localparam int IDLE_PCT      = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int SETTLE_END    = 2 * SLOT_COUNT + 16;
    localparam int STALL_LIMIT   = 4000;

    // One command transaction
    typedef struct packed {
        cmd_t             op;
        logic [ID_W-1:0]  idx;
        logic [VAL_W-1:0] val;
    } slot_req_t;

    // One result transaction
    typedef struct packed {
        status_t            st;
        logic [GIVEN_W-1:0] slot;
        logic [ID_W-1:0]    who;
        logic [COST_W-1:0]  cost;
    } alloc_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         cmd = '0;
    logic [ID_W-1:0]    index = '0;
    logic [VAL_W-1:0]   value = '0;
    logic               done;
    logic [2:0]         status;
    logic [GIVEN_W-1:0] slot_given;
    logic [ID_W-1:0]    served_id;
    logic [COST_W-1:0]  total_cost;

    slot_req_t     pending_cmds[$];
    alloc_result_t expected_results[$];
    int            n_errors = 0;
    int            n_accepted = 0;
    int            stall_cycles = 0;

    // Shadow of the allocator state
    bit [VAL_W-1:0]  slot_rate_tab[SLOT_COUNT];
    bit [VAL_W-1:0]  weight_tab[REQ_COUNT];
    bit [ID_W-1:0]   holder_id[SLOT_COUNT];
    bit [ID_W-1:0]   waiting_ids[$];
    bit [COST_W-1:0] cost_total = '0;
    bit [CFG_W-1:0]  slots_cfg = SLOTS_IN_USE_RST;

    // Stimulus bookkeeping: never read a rate or weight that was not loaded
    bit rate_loaded[SLOT_COUNT];
    bit weight_loaded[REQ_COUNT];
    int id_pool[$];

    wire quiet_run = (n_accepted >= 400) && (n_accepted < 700);

    lowest_free_slot_allocator_fifo_wait_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .index      (index),
        .value      (value),
        .done       (done),
        .status     (status),
        .slot_given (slot_given),
        .served_id  (served_id),
        .total_cost (total_cost)
    );

    always #2 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic int lowest_free_slot();
        int n;
        n = (slots_cfg > SLOT_COUNT) ? SLOT_COUNT : slots_cfg;
        for (int i = 0; i < n; i++)
        begin
            if (holder_id[i] == 0)
                return i;
        end
        return -1;
    endfunction

    // Give slot s to requester id and charge weight times rate
    function automatic void charge_slot(int s, logic [ID_W-1:0] id);
        holder_id[s] = id;
        cost_total = cost_total + weight_tab[id] * slot_rate_tab[s];
    endfunction

    function automatic alloc_result_t allot_step(cmd_t op, logic [ID_W-1:0] idx,
                                                 logic [VAL_W-1:0] val);
        alloc_result_t r;
        int            s;
        int            n;
        logic [ID_W-1:0] head;
        r.st   = RES_NOT_FOUND;
        r.slot = '0;
        r.who  = '0;
        n = (slots_cfg > SLOT_COUNT) ? SLOT_COUNT : slots_cfg;
        if (op == CMD_LOAD_RATE)
        begin
            if (idx < SLOT_COUNT)
                slot_rate_tab[idx] = val;
            r.st = RES_LOADED;
        end
        else if (op == CMD_LOAD_WEIGHT)
        begin
            if (idx < REQ_COUNT)
                weight_tab[idx] = val;
            r.st = RES_LOADED;
        end
        else if (idx != 0 && idx < REQ_COUNT)
        begin
            if (op == CMD_ARRIVE)
            begin
                s = lowest_free_slot();
                if (s >= 0)
                begin
                    charge_slot(s, idx);
                    r.st   = RES_PLACED;
                    r.slot = s[GIVEN_W-1:0];
                    r.who  = idx;
                end
                else if (waiting_ids.size() < REQ_COUNT)
                begin
                    waiting_ids.push_back(idx);
                    r.st = RES_QUEUED;
                end
            end
            else
            begin
                // departure frees only the lowest active slot held by idx
                s = -1;
                for (int i = 0; i < n; i++)
                begin
                    if (s < 0 && holder_id[i] == idx)
                        s = i;
                end
                if (s >= 0)
                begin
                    holder_id[s] = '0;
                    r.st = RES_FREED;
                    if (waiting_ids.size() != 0)
                    begin
                        s = lowest_free_slot();
                        if (s >= 0)
                        begin
                            head = waiting_ids.pop_front();
                            charge_slot(s, head);
                            r.st   = RES_SERVED;
                            r.slot = s[GIVEN_W-1:0];
                            r.who  = head;
                        end
                    end
                end
            end
        end
        r.cost = cost_total;
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string field, logic [COST_W-1:0] got,
                                   logic [COST_W-1:0] want);
        $display("%0t ns mismatch %s: got %0h want %0h", $time, field, got, want);
        n_errors++;
    endtask

    // Monitor: config writes, result checks, command acceptance, watchdog
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n)
        begin
            if (cfg_we)
                slots_cfg = cfg_wdata;
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, status", status, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (slot_given !== want.slot)
                        report_mismatch("slot_given", slot_given, want.slot);
                    if (served_id !== want.who)
                        report_mismatch("served_id", served_id, want.who);
                    if (total_cost !== want.cost)
                        report_mismatch("total_cost", total_cost, want.cost);
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(allot_step(cmd_t'(cmd), index, value));
                pending_cmds.delete(0);
                n_accepted++;
            end
            stall_cycles = (done || cfg_we || (start && !busy)) ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Driver: present the oldest pending command, idling at random
    always @(negedge clk)
    begin
        if (rst_n && pending_cmds.size() != 0 &&
            (quiet_run || $urandom_range(0, 99) >= IDLE_PCT))
        begin
            start <= 1'b1;
            cmd   <= pending_cmds[0].op;
            index <= pending_cmds[0].idx;
            value <= pending_cmds[0].val;
        end
        else
            start <= 1'b0;
    end

    // ---------------- stimulus ----------------

    task automatic queue_cmd(cmd_t op, int idx, int val);
        slot_req_t item;
        item.op  = op;
        item.idx = idx[ID_W-1:0];
        item.val = val[VAL_W-1:0];
        pending_cmds.push_back(item);
        if (op == CMD_LOAD_RATE && idx < SLOT_COUNT)
            rate_loaded[idx] = 1'b1;
        if (op == CMD_LOAD_WEIGHT)
            weight_loaded[idx] = 1'b1;
    endtask

    // Arrival, preceded by a weight load if this requester has none yet
    task automatic queue_arrival(int id);
        if (id != 0 && !weight_loaded[id])
            queue_cmd(CMD_LOAD_WEIGHT, id, $urandom_range(0, VAL_MAX));
        queue_cmd(CMD_ARRIVE, id, $urandom_range(0, VAL_MAX));
    endtask

    function automatic int pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        else if (r < 97)
            return $urandom_range(1, REQ_COUNT - 1);
        return 0;
    endfunction

    // Wait for the block to drain, write slots_in_use, then load missing rates
    task automatic set_slots(int n);
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        for (int s = 0; s < n; s++)
        begin
            if (!rate_loaded[s])
                queue_cmd(CMD_LOAD_RATE, s, $urandom_range(0, VAL_MAX));
        end
    endtask

    // Random traffic over a small requester pool so departures mostly hit
    task automatic run_random_phase(int n_items, int n_slots, int arrive_pct);
        int r;
        set_slots(n_slots);
        id_pool.delete();
        for (int k = 0; k < ((n_slots + 4 < 48) ? n_slots + 4 : 48); k++)
            id_pool.push_back($urandom_range(1, REQ_COUNT - 1));
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                queue_cmd(CMD_LOAD_RATE, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, REQ_COUNT - 1) : $urandom_range(0, SLOT_COUNT - 1),
                          $urandom_range(0, VAL_MAX));
            else if (r < 14)
                queue_cmd(CMD_LOAD_WEIGHT, $urandom_range(0, 1) ?
                          pick_id() : $urandom_range(0, REQ_COUNT - 1),
                          $urandom_range(0, VAL_MAX));
            else if (r < 14 + arrive_pct)
                queue_arrival(pick_id());
            else
                queue_cmd(CMD_DEPART, pick_id(), $urandom_range(0, VAL_MAX));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: two usable slots, extremes, bad ids, repeats, queue and serve
        set_slots(2);
        queue_cmd(CMD_LOAD_RATE, 0, VAL_MAX);
        queue_cmd(CMD_LOAD_RATE, 1, 0);
        queue_cmd(CMD_LOAD_RATE, REQ_COUNT - 1, $urandom_range(0, VAL_MAX)); // out of range
        queue_cmd(CMD_LOAD_RATE, SLOT_COUNT - 1, 1);                         // inactive slot
        queue_cmd(CMD_LOAD_WEIGHT, REQ_COUNT - 1, VAL_MAX);
        queue_cmd(CMD_LOAD_WEIGHT, 0, 16'h1234);
        queue_cmd(CMD_LOAD_WEIGHT, 1, 16'h8000);
        queue_cmd(CMD_ARRIVE, 0, VAL_MAX);          // id zero
        queue_cmd(CMD_DEPART, 0, 0);                // id zero
        queue_cmd(CMD_ARRIVE, REQ_COUNT - 1, 0);    // slot 0
        queue_cmd(CMD_ARRIVE, REQ_COUNT - 1, 0);    // same requester, slot 1
        queue_cmd(CMD_ARRIVE, 1, 0);                // queued
        queue_cmd(CMD_ARRIVE, REQ_COUNT - 1, 0);    // queued again
        queue_cmd(CMD_DEPART, 1024, 0);             // holds nothing
        queue_cmd(CMD_DEPART, REQ_COUNT - 1, 0);    // frees slot 0, serves 1
        queue_cmd(CMD_DEPART, REQ_COUNT - 1, 0);    // frees slot 1, serves itself
        queue_cmd(CMD_DEPART, 1, 0);
        queue_cmd(CMD_DEPART, REQ_COUNT - 1, 0);
        queue_cmd(CMD_DEPART, REQ_COUNT - 1, 0);    // nothing left to free

        // Random phases over several slot ranges, extremes included
        run_random_phase(250, SLOT_COUNT, 70);
        run_random_phase(150, 1, 40);
        run_random_phase(175, 5, 43);
        run_random_phase(175, SLOT_COUNT, 43);
        run_random_phase(175, $urandom_range(2, SLOT_COUNT - 1), 43);
        run_random_phase(150, 3, 40);
        run_random_phase(175, 64, 50);
        run_random_phase(150, 1, 43);

        // Build a long wait queue with one slot, then serve from it
        set_slots(1);
        for (int k = 0; k < 96; k++)
            queue_arrival(id_pool[$urandom_range(0, id_pool.size() - 1)]);
        for (int k = 0; k < 16; k++)
        begin
            if (k % 2 == 1)
                queue_arrival(id_pool[$urandom_range(0, id_pool.size() - 1)]);
            else
                queue_cmd(CMD_DEPART, id_pool[$urandom_range(0, id_pool.size() - 1)],
                          $urandom_range(0, VAL_MAX));
        end

        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_END) @(posedge clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
